/* sv/f2h8_pkg.sv */
// ----------------------------------------------------------------------------
// f2h8_pkg
// Shared types and constants for the float to HiFloat8 encoder.
// ----------------------------------------------------------------------------
package f2h8_pkg;

    // Source format select
    typedef logic [1:0] fmt_t;

    localparam fmt_t FMT_FP32 = 2'd0;
    localparam fmt_t FMT_FP16 = 2'd1;
    localparam fmt_t FMT_BF16 = 2'd2;

    // Unbiased exponent, wide enough for every source format
    typedef logic signed [8:0] exp_t;

    localparam exp_t BIAS_FP32     = 9'sd127;
    localparam exp_t BIAS_FP16     = 9'sd15;
    localparam exp_t EXP_FLUSH_MIN = -9'sd22;  // below this flush to zero
    localparam exp_t EXP_NORM_MIN  = -9'sd15;  // lowest dot-coded exponent
    localparam exp_t EXP_SAT       = 9'sd15;   // this and above saturate

    localparam logic [4:0] DENORM_OFFSET = 5'd23;
    localparam logic [4:0] DENORM_LIMIT  = 5'd8;

    // Fixed output codes; magnitudes take the sign in bit 7
    localparam logic [7:0] HIF8_NAN      = 8'h80;
    localparam logic [7:0] HIF8_ZERO     = 8'h00;
    localparam logic [6:0] HIF8_INF_MAG  = 7'h6F;
    localparam logic [6:0] HIF8_SAT_MAG  = 7'h6E;
    localparam logic [6:0] HIF8_EXP_M15  = 7'h7E;

endpackage

/* sv/f2h8_encode.sv */
// ----------------------------------------------------------------------------
// f2h8_encode
// Combinational conversion of one FP32, FP16 or BF16 pattern to HiFloat8.
// ----------------------------------------------------------------------------
module f2h8_encode (
    input  f2h8_pkg::fmt_t src_format,
    input  logic [31:0]    src_bits,
    output logic [7:0]     hif8_code
);

    logic              sign;
    logic [7:0]        exp_field;
    logic              exp_ones;
    logic [22:0]       frac;
    f2h8_pkg::exp_t    bias;
    f2h8_pkg::exp_t    e;

    logic [5:0]        e6;
    logic [5:0]        e6_abs;
    logic [3:0]        mag;
    logic              carry;
    logic [2:0]        q;
    logic [5:0]        e_fin;
    logic [5:0]        e_fin_abs;
    logic [3:0]        mag_fin;
    logic              neg_fin;
    logic [6:0]        norm_code;

    logic [4:0]        den_cnt;

    // Field extraction; fraction left-aligned to 23 bits
    always_comb
    begin
        case (src_format)
            f2h8_pkg::FMT_FP16:
            begin
                sign      = src_bits[15];
                exp_field = {3'b000, src_bits[14:10]};
                exp_ones  = &src_bits[14:10];
                frac      = {src_bits[9:0], 13'b0};
                bias      = f2h8_pkg::BIAS_FP16;
            end
            f2h8_pkg::FMT_BF16:
            begin
                sign      = src_bits[15];
                exp_field = src_bits[14:7];
                exp_ones  = &src_bits[14:7];
                frac      = {src_bits[6:0], 16'b0};
                bias      = f2h8_pkg::BIAS_FP32;
            end
            default:
            begin
                sign      = src_bits[31];
                exp_field = src_bits[30:23];
                exp_ones  = &src_bits[30:23];
                frac      = src_bits[22:0];
                bias      = f2h8_pkg::BIAS_FP32;
            end
        endcase
    end

    assign e = $signed({1'b0, exp_field}) - bias;

    // Round on one guard bit below the kept fraction; all ones carries out
    assign e6     = e[5:0];
    assign e6_abs = e6[5] ? (6'd0 - e6) : e6;
    assign mag    = e6_abs[3:0];

    always_comb
    begin
        if (mag <= 4'd3)
        begin
            carry = (&frac[22:20]) & frac[19];
            q     = frac[22:20] + {2'b00, frac[19]};
        end
        else if (mag <= 4'd7)
        begin
            carry = (&frac[22:21]) & frac[20];
            q     = {1'b0, frac[22:21] + {1'b0, frac[20]}};
        end
        else
        begin
            carry = frac[22] & frac[21];
            q     = {2'b00, frac[22] ^ frac[21]};
        end
        if (carry)
        begin
            q = 3'd0;
        end
    end

    assign e_fin     = e6 + {5'd0, carry};
    assign neg_fin   = e_fin[5];
    assign e_fin_abs = neg_fin ? (6'd0 - e_fin) : e_fin;
    assign mag_fin   = e_fin_abs[3:0];

    // Dot field picks exponent width from the magnitude of the exponent
    always_comb
    begin
        if (mag_fin == 4'd0)
        begin
            norm_code = {4'b0001, q};
        end
        else if (mag_fin == 4'd1)
        begin
            norm_code = {3'b001, neg_fin, q};
        end
        else if (mag_fin <= 4'd3)
        begin
            norm_code = {2'b01, neg_fin, mag_fin[0], q};
        end
        else if (mag_fin <= 4'd7)
        begin
            norm_code = {2'b10, neg_fin, mag_fin[1:0], q[1:0]};
        end
        else
        begin
            norm_code = {2'b11, neg_fin, mag_fin[2:0], q[0]};
        end
    end

    assign den_cnt = e[4:0] + f2h8_pkg::DENORM_OFFSET + {4'd0, frac[22]};

    always_comb
    begin
        if (exp_ones && (frac != 23'd0))
        begin
            hif8_code = f2h8_pkg::HIF8_NAN;
        end
        else if (exp_ones)
        begin
            hif8_code = {sign, f2h8_pkg::HIF8_INF_MAG};
        end
        else if ((exp_field == 8'd0) || (e < f2h8_pkg::EXP_FLUSH_MIN))
        begin
            hif8_code = f2h8_pkg::HIF8_ZERO;
        end
        else if (e >= f2h8_pkg::EXP_SAT)
        begin
            hif8_code = {sign, f2h8_pkg::HIF8_SAT_MAG};
        end
        else if (e < f2h8_pkg::EXP_NORM_MIN)
        begin
            // Denormal count that rounds up to 8 becomes 2^-15
            if (den_cnt >= f2h8_pkg::DENORM_LIMIT)
            begin
                hif8_code = {sign, f2h8_pkg::HIF8_EXP_M15};
            end
            else
            begin
                hif8_code = {sign, 4'b0000, den_cnt[2:0]};
            end
        end
        else
        begin
            hif8_code = {sign, norm_code};
        end
    end

endmodule

/* sv/float_to_hifloat8_encoder_top.sv */
// Pipeline: a transaction passes through the input register, then the result
//   register, and is held on the output until taken.
// Throughput: one transaction per cycle while out_stall is low; the encoder is
//   a single pass of combinational logic between the two registers.
// Reset: clears both valid flags and sets the source format to FP32.
// ----------------------------------------------------------------------------
// float_to_hifloat8_encoder_top
// Two-register pipeline converting FP32/FP16/BF16 values to HiFloat8 bytes.
// ----------------------------------------------------------------------------
module float_to_hifloat8_encoder_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] src_bits,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  hif8_code
);

    f2h8_pkg::fmt_t fmt_reg;
    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [31:0]    s1_bits_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     code_reg;
    logic [7:0]     code_next;

    logic           out_load;
    logic           s1_load;

    // Advance a stage when the one after it is empty or moving
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || out_load;
    assign in_stall = !s1_load;

    assign s1_valid_next  = s1_load ? in_valid : s1_valid_reg;
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    f2h8_encode u_encode (
        .src_format (fmt_reg),
        .src_bits   (s1_bits_reg),
        .hif8_code  (code_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= f2h8_pkg::FMT_FP32;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_bits_reg <= src_bits;
        end
        if (out_load && s1_valid_reg)
        begin
            code_reg <= code_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hif8_code = code_reg;

endmodule
